[hw/rtl/htfd_pkg.sv]
package htfd_pkg;

  localparam int ByteW  = 8;
  localparam int PosW   = 3;
  localparam int RawW   = 20;
  localparam int TempW  = 29;
  localparam int StatW  = 2;
  localparam int ProdW  = 28;

  localparam logic [ByteW-1:0] CrcInit = 8'hFF;
  localparam logic [ByteW-1:0] CrcPoly = 8'h31;
  localparam int               BusyBit = 7;

  localparam logic [ByteW-1:0]  TempScale  = 8'd200;
  localparam logic [TempW-1:0]  TempOffset = 29'd52428800;

  // byte positions inside the measurement frame
  localparam logic [PosW-1:0] PosStatus  = 3'd0;
  localparam logic [PosW-1:0] PosHumHi   = 3'd1;
  localparam logic [PosW-1:0] PosHumMid  = 3'd2;
  localparam logic [PosW-1:0] PosMixed   = 3'd3;
  localparam logic [PosW-1:0] PosTempMid = 3'd4;
  localparam logic [PosW-1:0] PosTempLo  = 3'd5;
  localparam logic [PosW-1:0] PosCrc     = 3'd6;

  typedef enum logic [StatW-1:0] {
    STAT_SUCCESS  = 2'd0,
    STAT_BUSY     = 2'd1,
    STAT_CRC_FAIL = 2'd2
  } status_t;

  typedef struct packed {
    logic            crc_ok;
    logic            busy;
    logic [RawW-1:0] humidity;
    logic [RawW-1:0] temp_raw;
  } frame_info_t;

  // crc-8, msb first, one byte per call
  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < ByteW; k++) begin
      if (c[ByteW-1]) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/humidity_temp_frame_decoder.sv]
// humidity / temperature measurement frame decoder
// input stream: one frame byte per request; s_tuser high marks the first byte
// of a frame and drops any partial frame in progress
// a frame is 7 bytes: sensor status, 20-bit humidity, 20-bit temperature,
// then a crc-8 (poly 0x31, init 0xff) over the first six bytes
// output stream: one request after the seventh byte carrying status (crc fail
// before busy before success), humidity fraction and temperature in q20
// throughput: one byte per cycle, sustained, but a check byte waits while a result is held
// result path: the check byte is taken into the input register, status and
// temperature are formed from it there, then it moves into the result
// register, which drives m_tvalid
// reset: frame position back to the first byte, crc back to 0xff, both
// registers emptied
// stall: a held result blocks only a following check byte; the data bytes of
// the next frame keep flowing in while the result waits
module humidity_temp_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  // slave side: tdata = rx_byte[7:0]; tuser = frame_start
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  // master side: tdata = status[1:0], humidity_fraction[21:2],
  // temperature_q20[50:22], zero fill[55:51]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata
);
  import htfd_pkg::*;

  logic        done_valid;
  logic        done_ready;
  frame_info_t done;

  // byte capture, crc and field assembly
  htfd_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done       (done)
  );

  // status decision, temperature scaling, output register
  htfd_result u_result (
    .clk        (clk),
    .rst        (rst),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done       (done),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

[hw/rtl/htfd_frame.sv]
module htfd_frame (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [htfd_pkg::ByteW-1:0]   s_tdata,
  input  logic                         s_tuser,
  output logic                         done_valid,
  input  logic                         done_ready,
  output htfd_pkg::frame_info_t        done
);
  import htfd_pkg::*;

  // input register
  logic             in_vld;
  logic [ByteW-1:0] in_byte;
  logic             in_start;

  // frame state
  logic [PosW-1:0]  pos;
  logic [ByteW-1:0] crc;
  logic [ByteW-1:0] stat_hold;
  logic [RawW-1:0]  hum;
  logic [RawW-1:0]  temp;

  logic             restart;
  logic [PosW-1:0]  pos_eff;
  logic [ByteW-1:0] crc_eff;
  logic             is_last;
  logic             advance;

  assign restart = in_start || (pos > PosCrc);
  assign pos_eff = restart ? PosStatus : pos;
  assign crc_eff = restart ? CrcInit : crc;
  assign is_last = (pos_eff == PosCrc);

  // only the check byte needs room downstream
  assign advance  = in_vld && (!is_last || done_ready);
  assign s_tready = !in_vld || advance;

  assign done_valid      = in_vld && is_last;
  assign done.crc_ok     = (crc_eff == in_byte);
  assign done.busy       = stat_hold[BusyBit];
  assign done.humidity   = hum;
  assign done.temp_raw   = temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= PosStatus;
      crc <= CrcInit;
    end else if (advance) begin
      if (is_last) begin
        pos <= PosStatus;
        crc <= CrcInit;
      end else begin
        pos <= pos_eff + 3'd1;
        crc <= crc8_byte(crc_eff, in_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      case (pos_eff)
        PosStatus:  stat_hold <= in_byte;
        PosHumHi:   hum <= {in_byte, 12'h000};
        PosHumMid:  hum <= hum | {8'h00, in_byte, 4'h0};
        PosMixed: begin
          hum  <= hum | {16'h0000, in_byte[7:4]};
          temp <= {in_byte[3:0], 16'h0000};
        end
        PosTempMid: temp <= temp | {4'h0, in_byte, 8'h00};
        PosTempLo:  temp <= temp | {12'h000, in_byte};
        default:    ;
      endcase
    end
  end

endmodule

[hw/rtl/htfd_result.sv]
module htfd_result (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        done_valid,
  output logic                        done_ready,
  input  htfd_pkg::frame_info_t       done,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [55:0]                 m_tdata
);
  import htfd_pkg::*;

  status_t          status_next;
  logic [ProdW-1:0] prod;
  logic [TempW-1:0] temp_next;

  status_t          status;
  logic [RawW-1:0]  humidity;
  logic [TempW-1:0] temperature;

  assign done_ready = !m_tvalid || m_tready;

  always_comb begin
    if (!done.crc_ok) begin
      status_next = STAT_CRC_FAIL;
    end else if (done.busy) begin
      status_next = STAT_BUSY;
    end else begin
      status_next = STAT_SUCCESS;
    end
  end

  // raw * 200 - 50 * 2^20, exact in 29 bits
  assign prod      = ProdW'(done.temp_raw) * ProdW'(TempScale);
  assign temp_next = {1'b0, prod} - TempOffset;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done_ready) begin
      m_tvalid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_ready && done_valid) begin
      status      <= status_next;
      humidity    <= done.humidity;
      temperature <= temp_next;
    end
  end

  assign m_tdata = {5'b00000, temperature, humidity, status};

endmodule
